// File: hw/rtl/ntcbt_pkg.sv
// ----------------------------------------------------------------------------
// ntcbt_pkg
// Shared widths, constants and types of the NTC beta temperature converter.
// ----------------------------------------------------------------------------
package ntcbt_pkg;

	localparam int ADC_BITS_DEF = 12;
	localparam int CODE_W       = 12;
	localparam int RES_W        = 20;
	localparam int BETA_W       = 14;
	localparam int T0_W         = 15;
	localparam int TEMP_W       = 18;
	localparam int FAULT_W      = 2;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 20;

	localparam int M_W          = 31;
	localparam int FRAC_BITS    = 24;
	localparam int LN2_W        = 32;
	localparam int INV_NUM_W    = 37;
	localparam int T0K_W        = 16;
	localparam int INV0_W       = 24;
	localparam int TK_W         = 17;

	localparam logic [LN2_W-1:0]     LN2_Q32 = 32'hB17217F8;
	localparam logic [INV_NUM_W-1:0] INV_NUM = 37'h19_0000_0000;

	localparam logic signed [TEMP_W-1:0] OUT_MIN      = -18'sd27315;
	localparam logic signed [TEMP_W-1:0] OUT_MAX      = 18'sd100000;
	localparam logic signed [TEMP_W-1:0] SHORT_TEMP   = -18'sd4000;
	localparam logic signed [TEMP_W-1:0] KELVIN_CENTI = 18'sd27315;
	localparam logic [TK_W-1:0]          TK_MAX       = 17'd127315;

	localparam logic [RES_W-1:0]  SERIES_RST = 20'd10000;
	localparam logic [RES_W-1:0]  NOMINAL_RST = 20'd10000;
	localparam logic [BETA_W-1:0] BETA_RST   = 14'd3950;
	localparam logic [T0_W-1:0]   T0_RST     = 15'd2500;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SERIES  = 2'd0,
		REG_NOMINAL = 2'd1,
		REG_BETA    = 2'd2,
		REG_T0      = 2'd3
	} reg_idx_t;

	typedef enum logic [FAULT_W-1:0] {
		FAULT_OK    = 2'd0,
		FAULT_SHORT = 2'd1,
		FAULT_OPEN  = 2'd2
	} fault_t;

	// forced result travelling alongside a request
	typedef struct packed {
		logic                     ovr;
		logic signed [TEMP_W-1:0] temp;
		fault_t                   fault;
	} ovr_t;

endpackage

// File: hw/rtl/ntcbt_log_cell.sv
// ----------------------------------------------------------------------------
// ntcbt_log_cell
// One log2 fraction bit for two lanes: square the mantissa, renormalise.
// ----------------------------------------------------------------------------
module ntcbt_log_cell #(
	parameter int FW = 30,
	parameter int SW = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     vld_i,
	input  logic [ntcbt_pkg::M_W-1:0] m_a_i,
	input  logic [ntcbt_pkg::M_W-1:0] m_b_i,
	input  logic [FW-1:0]            l_a_i,
	input  logic [FW-1:0]            l_b_i,
	input  logic [SW-1:0]            side_i,
	output logic                     vld_o,
	output logic [ntcbt_pkg::M_W-1:0] m_a_o,
	output logic [ntcbt_pkg::M_W-1:0] m_b_o,
	output logic [FW-1:0]            l_a_o,
	output logic [FW-1:0]            l_b_o,
	output logic [SW-1:0]            side_o
);
	import ntcbt_pkg::*;

	logic [2*M_W-1:0] sq_a, sq_b;
	logic [M_W:0]     t_a, t_b;

	assign sq_a = (2*M_W)'(m_a_i) * (2*M_W)'(m_a_i);
	assign sq_b = (2*M_W)'(m_b_i) * (2*M_W)'(m_b_i);
	assign t_a  = sq_a[2*M_W-1:M_W-1];
	assign t_b  = sq_b[2*M_W-1:M_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_a_o  <= t_a[M_W] ? t_a[M_W:1] : t_a[M_W-1:0];
			m_b_o  <= t_b[M_W] ? t_b[M_W:1] : t_b[M_W-1:0];
			l_a_o  <= {l_a_i[FW-2:0], t_a[M_W]};
			l_b_o  <= {l_b_i[FW-2:0], t_b[M_W]};
			side_o <= side_i;
		end
	end

endmodule

// File: hw/rtl/ntcbt_div_cell.sv
// ----------------------------------------------------------------------------
// ntcbt_div_cell
// One restoring division step: shift in a dividend bit, subtract if it fits.
// ----------------------------------------------------------------------------
module ntcbt_div_cell #(
	parameter int DW = 16,
	parameter int NW = 16,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_i,
	input  logic [DW-1:0] rem_i,
	input  logic [NW-1:0] num_i,
	input  logic [DW-1:0] den_i,
	input  logic [SW-1:0] side_i,
	output logic          vld_o,
	output logic [DW-1:0] rem_o,
	output logic [NW-1:0] num_o,
	output logic [DW-1:0] den_o,
	output logic [SW-1:0] side_o
);
	logic [DW:0] t;
	logic [DW:0] diff;
	logic        ge;

	assign t    = {rem_i, num_i[NW-1]};
	assign diff = t - {1'b0, den_i};
	assign ge   = t >= {1'b0, den_i};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o  <= ge ? diff[DW-1:0] : t[DW-1:0];
			num_o  <= {num_i[NW-2:0], ge};
			den_o  <= den_i;
			side_o <= side_i;
		end
	end

endmodule

// File: hw/rtl/ntc_beta_temperature_convert_core.sv
// ----------------------------------------------------------------------------
// ntc_beta_temperature_convert_core
// NTC thermistor ADC code to centidegrees Celsius via the beta equation.
// ----------------------------------------------------------------------------
// Input request: adc_code on in_valid/in_ready. Output request:
// temperature_centi and fault_code on out_valid/out_ready, one per input,
// in order. Config: cfg_index/cfg_data on cfg_valid/cfg_ready, always ready.
// The datapath is a row of squaring cells for both logs, a row of divider
// cells for ln/beta (37 cells above 12 bits) and a row for 1/invT.
// Throughput is one request per cycle while the receiver does not stall and
// 1/T0 is not being worked out.
// 1/T0 is worked out by one divider cell stepped 37 times; while it runs,
// after reset and after every config write, in_ready is low.
// A stalled receiver freezes the whole row; in_ready then follows out_ready.
// ----------------------------------------------------------------------------
module ntc_beta_temperature_convert_core #(
	parameter int ADC_BITS = ntcbt_pkg::ADC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [ntcbt_pkg::CODE_W-1:0]         adc_code,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [ntcbt_pkg::TEMP_W-1:0]  temperature_centi,
	output logic [ntcbt_pkg::FAULT_W-1:0]        fault_code,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ntcbt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ntcbt_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import ntcbt_pkg::*;

	localparam int XW     = RES_W + ADC_BITS;
	localparam int LW     = (XW > M_W) ? XW : M_W;
	localparam int PW     = $clog2(LW);
	localparam int FW     = PW + FRAC_BITS;
	localparam int PRW    = FW + LN2_W;
	localparam int TQ_W   = PRW + 1 - 26;
	localparam int IT_W   = TQ_W + 2;
	localparam int ID_W   = TQ_W + 1;
	localparam int DV2_W  = ((TQ_W > INV_NUM_W) ? TQ_W : INV_NUM_W) + 1;
	localparam int HI_W   = DV2_W - TK_W;
	localparam int OVR_W  = $bits(ovr_t);
	localparam int LS_W   = BETA_W + OVR_W;
	localparam int D1S_W  = 1 + OVR_W;
	localparam int CNT_W  = $clog2(INV_NUM_W + 1);
	localparam logic [ADC_BITS-1:0] FULL = {ADC_BITS{1'b1}};

	// configuration
	logic [RES_W-1:0]  series_q, nominal_q;
	logic [BETA_W-1:0] beta_q;
	logic [T0_W-1:0]   t0_q;
	logic              cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			series_q  <= SERIES_RST;
			nominal_q <= NOMINAL_RST;
			beta_q    <= BETA_RST;
			t0_q      <= T0_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SERIES:  series_q  <= cfg_data;
				REG_NOMINAL: nominal_q <= cfg_data;
				REG_BETA:    beta_q    <= cfg_data[BETA_W-1:0];
				REG_T0:      t0_q      <= cfg_data[T0_W-1:0];
			endcase
		end
	end

	// 1/T0 sequencer
	logic                   busy_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [INV0_W-1:0]      inv_t0_q;
	logic signed [T0K_W:0]  t0k_full;
	logic [T0K_W-1:0]       t0k;
	logic [INV_NUM_W-1:0]   dvd0;
	logic                   sq_vld_i, sq_vld_o;
	logic [T0K_W-1:0]       sq_rem_i, sq_rem_o, sq_den_i, sq_den_o;
	logic [INV_NUM_W-1:0]   sq_num_i, sq_num_o;
	logic                   sq_side_o;
	logic                   sq_first;

	assign t0k_full = $signed({{2{t0_q[T0_W-1]}}, t0_q}) + (T0K_W+1)'(27315);
	assign t0k      = t0k_full[T0K_W-1:0];
	assign dvd0     = INV_NUM + INV_NUM_W'(t0k >> 1);
	assign sq_first = (cnt_q == '0);
	assign sq_vld_i = sq_first ? 1'b1 : sq_vld_o;
	assign sq_rem_i = sq_first ? '0 : sq_rem_o;
	assign sq_num_i = sq_first ? dvd0 : sq_num_o;
	assign sq_den_i = sq_first ? t0k : sq_den_o;

	ntcbt_div_cell #(.DW(T0K_W), .NW(INV_NUM_W), .SW(1)) u_inv0 (
		.clk(clk), .arst_n(arst_n), .en(busy_q),
		.vld_i(sq_vld_i), .rem_i(sq_rem_i), .num_i(sq_num_i), .den_i(sq_den_i),
		.side_i(sq_side_o),
		.vld_o(sq_vld_o), .rem_o(sq_rem_o), .num_o(sq_num_o), .den_o(sq_den_o),
		.side_o(sq_side_o)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (cfg_wr) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == CNT_W'(INV_NUM_W)) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && cnt_q == CNT_W'(INV_NUM_W)) begin
			inv_t0_q <= sq_num_o[INV0_W-1:0];
		end
	end

	// flow control
	logic out_vld_q;
	logic adv;

	assign adv       = !out_vld_q || out_ready;
	assign in_ready  = adv && !busy_q;
	assign out_valid = out_vld_q;

	// S1: products and special cases
	logic [15:0]         code_ext;
	logic [ADC_BITS-1:0] code;
	ovr_t                ovr_c;
	logic                vld_s1;
	logic [XW-1:0]       num_s1, den_s1;
	logic [BETA_W-1:0]   b_s1;
	ovr_t                ovr_s1;

	assign code_ext = 16'(adc_code);
	assign code     = code_ext[ADC_BITS-1:0];

	always_comb begin
		ovr_c.ovr   = 1'b0;
		ovr_c.temp  = OUT_MIN;
		ovr_c.fault = FAULT_OK;
		priority if (code == '0 || series_q == '0) begin
			ovr_c.ovr   = 1'b1;
			ovr_c.temp  = SHORT_TEMP;
			ovr_c.fault = FAULT_SHORT;
		end else if (code == FULL) begin
			ovr_c.ovr   = 1'b1;
			ovr_c.fault = FAULT_OPEN;
		end else if (nominal_q == '0) begin
			ovr_c.ovr   = 1'b1;
		end else begin
			ovr_c.ovr   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid && !busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s1 <= XW'(series_q) * XW'(code);
			den_s1 <= XW'(FULL - code) * XW'(nominal_q);
			b_s1   <= (beta_q == '0) ? BETA_W'(1) : beta_q;
			ovr_s1 <= ovr_c;
		end
	end

	// S2: top set bit
	logic          vld_s2;
	logic [LW-1:0] xa_s2, xb_s2;
	logic [PW-1:0] pa_c, pb_c, pa_s2, pb_s2;
	logic [LS_W-1:0] side_s2;
	logic [LW-1:0] xa_e, xb_e;

	assign xa_e = LW'(num_s1);
	assign xb_e = LW'(den_s1);

	always_comb begin
		pa_c = '0;
		pb_c = '0;
		for (int i = 0; i < LW; i++) begin
			if (xa_e[i]) pa_c = PW'(i);
			if (xb_e[i]) pb_c = PW'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xa_s2   <= xa_e;
			xb_s2   <= xb_e;
			pa_s2   <= pa_c;
			pb_s2   <= pb_c;
			side_s2 <= {b_s1, ovr_s1};
		end
	end

	// S3: normalise into the first cell
	logic          vld_lc  [0:FRAC_BITS];
	logic [M_W-1:0] ma_lc  [0:FRAC_BITS];
	logic [M_W-1:0] mb_lc  [0:FRAC_BITS];
	logic [FW-1:0]  la_lc  [0:FRAC_BITS];
	logic [FW-1:0]  lb_lc  [0:FRAC_BITS];
	logic [LS_W-1:0] sd_lc [0:FRAC_BITS];
	logic [LW-1:0]  xa_sh, xb_sh;

	assign xa_sh = xa_s2 << (PW'(LW - 1) - pa_s2);
	assign xb_sh = xb_s2 << (PW'(LW - 1) - pb_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_lc[0] <= 1'b0;
		end else if (adv) begin
			vld_lc[0] <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ma_lc[0] <= xa_sh[LW-1 -: M_W];
			mb_lc[0] <= xb_sh[LW-1 -: M_W];
			la_lc[0] <= FW'(pa_s2);
			lb_lc[0] <= FW'(pb_s2);
			sd_lc[0] <= side_s2;
		end
	end

	for (genvar g = 0; g < FRAC_BITS; g++) begin : g_log
		ntcbt_log_cell #(.FW(FW), .SW(LS_W)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.vld_i(vld_lc[g]), .m_a_i(ma_lc[g]), .m_b_i(mb_lc[g]),
			.l_a_i(la_lc[g]), .l_b_i(lb_lc[g]), .side_i(sd_lc[g]),
			.vld_o(vld_lc[g+1]), .m_a_o(ma_lc[g+1]), .m_b_o(mb_lc[g+1]),
			.l_a_o(la_lc[g+1]), .l_b_o(lb_lc[g+1]), .side_o(sd_lc[g+1])
		);
	end

	// S4: log difference
	logic              vld_s4, neg_s4;
	logic [FW-1:0]     dmag_s4;
	logic [BETA_W-1:0] b_s4;
	ovr_t              ovr_s4;
	logic [FW-1:0]     lna, lnb;

	assign lna = la_lc[FRAC_BITS];
	assign lnb = lb_lc[FRAC_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_lc[FRAC_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s4  <= lna < lnb;
			dmag_s4 <= (lna < lnb) ? (lnb - lna) : (lna - lnb);
			{b_s4, ovr_s4} <= sd_lc[FRAC_BITS];
		end
	end

	// S5: times ln 2
	logic              vld_s5, neg_s5;
	logic [PRW-1:0]    prod_s5;
	logic [BETA_W-1:0] b_s5;
	ovr_t              ovr_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s5 <= PRW'(dmag_s4) * PRW'(LN2_Q32);
			neg_s5  <= neg_s4;
			b_s5    <= b_s4;
			ovr_s5  <= ovr_s4;
		end
	end

	// S6: rounding bias, drop 26 bits into the divider row
	logic [PRW:0]        rsum;
	logic                vld_d1 [0:TQ_W];
	logic [BETA_W-1:0]   rem_d1 [0:TQ_W];
	logic [TQ_W-1:0]     num_d1 [0:TQ_W];
	logic [BETA_W-1:0]   den_d1 [0:TQ_W];
	logic [D1S_W-1:0]    sd_d1  [0:TQ_W];

	assign rsum = (PRW+1)'(prod_s5) + ((PRW+1)'(b_s5) << 25);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_d1[0] <= 1'b0;
		end else if (adv) begin
			vld_d1[0] <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_d1[0] <= '0;
			num_d1[0] <= rsum[PRW:26];
			den_d1[0] <= b_s5;
			sd_d1[0]  <= {neg_s5, ovr_s5};
		end
	end

	for (genvar g = 0; g < TQ_W; g++) begin : g_div1
		ntcbt_div_cell #(.DW(BETA_W), .NW(TQ_W), .SW(D1S_W)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.vld_i(vld_d1[g]), .rem_i(rem_d1[g]), .num_i(num_d1[g]),
			.den_i(den_d1[g]), .side_i(sd_d1[g]),
			.vld_o(vld_d1[g+1]), .rem_o(rem_d1[g+1]), .num_o(num_d1[g+1]),
			.den_o(den_d1[g+1]), .side_o(sd_d1[g+1])
		);
	end

	// S7: 1/T
	logic                   vld_s7;
	logic signed [IT_W-1:0] inv_s7;
	ovr_t                   ovr_s7;
	logic                   neg_d;
	ovr_t                   ovr_d;
	logic signed [IT_W-1:0] inv0_e, tmag_e;

	assign {neg_d, ovr_d} = sd_d1[TQ_W];
	assign inv0_e = $signed(IT_W'(inv_t0_q));
	assign tmag_e = $signed(IT_W'(num_d1[TQ_W]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s7 <= vld_d1[TQ_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			inv_s7 <= neg_d ? (inv0_e - tmag_e) : (inv0_e + tmag_e);
			ovr_s7 <= ovr_d;
		end
	end

	// S8: sign checks and final dividend
	logic              vld_s8;
	logic [ID_W-1:0]   inv_s8;
	logic [DV2_W-1:0]  dvd2_s8;
	ovr_t              ovr_s8;
	ovr_t              ovr7_n;

	always_comb begin
		ovr7_n = ovr_s7;
		if (!ovr_s7.ovr) begin
			if (inv_s7 == '0) begin
				ovr7_n.ovr  = 1'b1;
				ovr7_n.temp = OUT_MAX;
			end else if (inv_s7[IT_W-1]) begin
				ovr7_n.ovr  = 1'b1;
				ovr7_n.temp = OUT_MIN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (adv) begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			inv_s8  <= inv_s7[ID_W-1:0];
			dvd2_s8 <= DV2_W'(INV_NUM) + DV2_W'(inv_s7[ID_W-1:1]);
			ovr_s8  <= ovr7_n;
		end
	end

	// S9: hot overflow check, load the last divider row
	logic             vld_d2 [0:TK_W];
	logic [ID_W-1:0]  rem_d2 [0:TK_W];
	logic [TK_W-1:0]  num_d2 [0:TK_W];
	logic [ID_W-1:0]  den_d2 [0:TK_W];
	logic [OVR_W-1:0] sd_d2  [0:TK_W];
	logic [HI_W-1:0]  hi8;
	ovr_t             ovr8_n;

	assign hi8 = dvd2_s8[DV2_W-1:TK_W];

	always_comb begin
		ovr8_n = ovr_s8;
		if (!ovr_s8.ovr && ID_W'(hi8) >= inv_s8) begin
			ovr8_n.ovr  = 1'b1;
			ovr8_n.temp = OUT_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_d2[0] <= 1'b0;
		end else if (adv) begin
			vld_d2[0] <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_d2[0] <= ID_W'(hi8);
			num_d2[0] <= dvd2_s8[TK_W-1:0];
			den_d2[0] <= inv_s8;
			sd_d2[0]  <= ovr8_n;
		end
	end

	for (genvar g = 0; g < TK_W; g++) begin : g_div2
		ntcbt_div_cell #(.DW(ID_W), .NW(TK_W), .SW(OVR_W)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.vld_i(vld_d2[g]), .rem_i(rem_d2[g]), .num_i(num_d2[g]),
			.den_i(den_d2[g]), .side_i(sd_d2[g]),
			.vld_o(vld_d2[g+1]), .rem_o(rem_d2[g+1]), .num_o(num_d2[g+1]),
			.den_o(den_d2[g+1]), .side_o(sd_d2[g+1])
		);
	end

	// S10: output register
	ovr_t                     ovr_f;
	logic [TK_W-1:0]          tk;
	logic signed [TEMP_W-1:0] temp_c;
	logic signed [TEMP_W-1:0] temp_q;
	fault_t                   fault_q;

	assign ovr_f = ovr_t'(sd_d2[TK_W]);
	assign tk    = num_d2[TK_W];

	always_comb begin
		priority if (ovr_f.ovr) begin
			temp_c = ovr_f.temp;
		end else if (tk > TK_MAX) begin
			temp_c = OUT_MAX;
		end else begin
			temp_c = $signed(TEMP_W'(tk)) - KELVIN_CENTI;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_d2[TK_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			temp_q  <= temp_c;
			fault_q <= ovr_f.fault;
		end
	end

	assign temperature_centi = temp_q;
	assign fault_code        = fault_q;

endmodule
